// ===== src/spi_pkg.sv =====
`default_nettype none

package spi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int MAG_W       = CROSS_W - 1;
    localparam int CHUNK_W     = (MAG_W + 2) / 3;
    localparam int PP_W        = COORD_WIDTH + CHUNK_W;
    localparam int NUM_W       = COORD_WIDTH + 3 * CHUNK_W;
    localparam int QUO_W       = COORD_WIDTH;
    localparam int TOL_W       = 16;
    localparam int NEAR_W      = 8;
    localparam int SQ_W        = 2 * NEAR_W + 1;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_CROSS   = 2'd1,
        KIND_OVERLAP = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_start_x;
        logic signed [FIELD_W-1:0] a_start_y;
        logic signed [FIELD_W-1:0] a_end_x;
        logic signed [FIELD_W-1:0] a_end_y;
        logic signed [FIELD_W-1:0] b_start_x;
        logic signed [FIELD_W-1:0] b_start_y;
        logic signed [FIELD_W-1:0] b_end_x;
        logic signed [FIELD_W-1:0] b_end_y;
    } t_req;

    typedef struct packed {
        logic [1:0]                contact_kind;
        logic [1:0]                point_count;
        logic signed [FIELD_W-1:0] first_x;
        logic signed [FIELD_W-1:0] first_y;
        logic signed [FIELD_W-1:0] second_x;
        logic signed [FIELD_W-1:0] second_y;
    } t_rsp;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_pt;

endpackage

`default_nettype wire

// ===== src/segment_pair_intersection_unit.sv =====
// throughput: one request per cycle, the whole pipeline holds while the result is stalled
// the crossing point comes from a 32-stage restoring divider, one quotient bit per stage
// reset (synchronous, active low) clears all stage valids and the merge tolerance
`default_nettype none

module segment_pair_intersection_unit
    import spi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_stall,
    input  wire t_req              i_req,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_stall,
    output t_rsp                   o_rsp,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [TOL_W-1:0]  i_cfg_wr_data
);

    localparam int NPROD = 10;
    localparam int NPAIR = 6;

    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;

    function automatic logic signed [COORD_WIDTH-1:0] f_sx(logic [FIELD_W-1:0] v);
        f_sx = v[COORD_WIDTH-1:0];
    endfunction

    function automatic t_diff f_sub(logic signed [COORD_WIDTH-1:0] a,
                                    logic signed [COORD_WIDTH-1:0] b);
        f_sub = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic [DIFF_W-1:0] f_abs_d(t_diff v);
        f_abs_d = (v < 0) ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    function automatic logic [MAG_W-1:0] f_abs_c(t_cross v);
        t_cross m;
        m = (v < 0) ? -v : v;
        f_abs_c = m[MAG_W-1:0];
    endfunction

    function automatic logic f_in_unit(t_cross t, t_cross den);
        if (den < 0) f_in_unit = (t <= 0) && (t >= den);
        else         f_in_unit = (t >= 0) && (t <= den);
    endfunction

    logic adv;
    assign adv         = !o_rsp_valid || !i_rsp_stall;
    assign o_req_stall = !adv;

    logic [TOL_W-1:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // s1: input register
    logic r_s1_vld;
    t_pt  r_s1_p [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_req_valid;
        end
        if (adv) begin
            r_s1_p[0] <= '{x: f_sx(i_req.a_start_x), y: f_sx(i_req.a_start_y)};
            r_s1_p[1] <= '{x: f_sx(i_req.a_end_x),   y: f_sx(i_req.a_end_y)};
            r_s1_p[2] <= '{x: f_sx(i_req.b_start_x), y: f_sx(i_req.b_start_y)};
            r_s1_p[3] <= '{x: f_sx(i_req.b_end_x),   y: f_sx(i_req.b_end_y)};
        end
    end

    // s2: differences
    // pair order: as-ae, as-bs, as-be, ae-bs, ae-be, bs-be
    logic  r_s2_vld;
    t_pt   r_s2_p [4];
    t_diff r_s2_dx [NPAIR];
    t_diff r_s2_dy [NPAIR];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld;
        end
        if (adv) begin
            r_s2_p     <= r_s1_p;
            r_s2_dx[0] <= f_sub(r_s1_p[0].x, r_s1_p[1].x);
            r_s2_dy[0] <= f_sub(r_s1_p[0].y, r_s1_p[1].y);
            r_s2_dx[1] <= f_sub(r_s1_p[0].x, r_s1_p[2].x);
            r_s2_dy[1] <= f_sub(r_s1_p[0].y, r_s1_p[2].y);
            r_s2_dx[2] <= f_sub(r_s1_p[0].x, r_s1_p[3].x);
            r_s2_dy[2] <= f_sub(r_s1_p[0].y, r_s1_p[3].y);
            r_s2_dx[3] <= f_sub(r_s1_p[1].x, r_s1_p[2].x);
            r_s2_dy[3] <= f_sub(r_s1_p[1].y, r_s1_p[2].y);
            r_s2_dx[4] <= f_sub(r_s1_p[1].x, r_s1_p[3].x);
            r_s2_dy[4] <= f_sub(r_s1_p[1].y, r_s1_p[3].y);
            r_s2_dx[5] <= f_sub(r_s1_p[2].x, r_s1_p[3].x);
            r_s2_dy[5] <= f_sub(r_s1_p[2].y, r_s1_p[3].y);
        end
    end

    // direction vectors and offsets from the pair differences
    t_diff dax, day, dbx, dby, dox, doy, ux, uy, vx, vy, wx, wy, zx, zy;
    always_comb begin
        dax = -r_s2_dx[0]; day = -r_s2_dy[0];
        dbx = -r_s2_dx[5]; dby = -r_s2_dy[5];
        dox = -r_s2_dx[1]; doy = -r_s2_dy[1];
        ux  =  r_s2_dx[1]; uy  =  r_s2_dy[1];
        vx  =  r_s2_dx[2]; vy  =  r_s2_dy[2];
        wx  =  r_s2_dx[3]; wy  =  r_s2_dy[3];
        zx  =  r_s2_dx[4]; zy  =  r_s2_dy[4];
    end

    // s3: products
    // 0 den, 1 cpar, 2 t, 3..5 on-line crosses, 6..9 dots
    logic                 r_s3_vld;
    t_pt                  r_s3_p [4];
    t_diff                r_s3_dax, r_s3_day;
    t_prod                r_s3_pa [NPROD];
    t_prod                r_s3_pb [NPROD];
    logic                 r_s3_near [NPAIR];
    logic [NEAR_W-1:0]    r_s3_mx [NPAIR];
    logic [NEAR_W-1:0]    r_s3_my [NPAIR];

    logic [DIFF_W-1:0] ax_mag [NPAIR];
    logic [DIFF_W-1:0] ay_mag [NPAIR];
    always_comb begin
        for (int k = 0; k < NPAIR; k++) begin
            ax_mag[k] = f_abs_d(r_s2_dx[k]);
            ay_mag[k] = f_abs_d(r_s2_dy[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld <= r_s2_vld;
        end
        if (adv) begin
            r_s3_p     <= r_s2_p;
            r_s3_dax   <= dax;
            r_s3_day   <= day;
            r_s3_pa[0] <= PROD_W'(dax) * PROD_W'(dby);
            r_s3_pb[0] <= PROD_W'(day) * PROD_W'(dbx);
            r_s3_pa[1] <= PROD_W'(dox) * PROD_W'(day);
            r_s3_pb[1] <= PROD_W'(doy) * PROD_W'(dax);
            r_s3_pa[2] <= PROD_W'(dox) * PROD_W'(dby);
            r_s3_pb[2] <= PROD_W'(doy) * PROD_W'(dbx);
            r_s3_pa[3] <= PROD_W'(ux) * PROD_W'(dby);
            r_s3_pb[3] <= PROD_W'(uy) * PROD_W'(dbx);
            r_s3_pa[4] <= PROD_W'(wx) * PROD_W'(dby);
            r_s3_pb[4] <= PROD_W'(wy) * PROD_W'(dbx);
            r_s3_pa[5] <= PROD_W'(vx) * PROD_W'(day);
            r_s3_pb[5] <= PROD_W'(vy) * PROD_W'(dax);
            r_s3_pa[6] <= PROD_W'(ux) * PROD_W'(vx);
            r_s3_pb[6] <= PROD_W'(uy) * PROD_W'(vy);
            r_s3_pa[7] <= PROD_W'(wx) * PROD_W'(zx);
            r_s3_pb[7] <= PROD_W'(wy) * PROD_W'(zy);
            r_s3_pa[8] <= PROD_W'(ux) * PROD_W'(wx);
            r_s3_pb[8] <= PROD_W'(uy) * PROD_W'(wy);
            r_s3_pa[9] <= PROD_W'(vx) * PROD_W'(zx);
            r_s3_pb[9] <= PROD_W'(vy) * PROD_W'(zy);
            for (int k = 0; k < NPAIR; k++) begin
                r_s3_near[k] <= (ax_mag[k] < DIFF_W'(1 << NEAR_W)) &&
                                (ay_mag[k] < DIFF_W'(1 << NEAR_W));
                r_s3_mx[k]   <= ax_mag[k][NEAR_W-1:0];
                r_s3_my[k]   <= ay_mag[k][NEAR_W-1:0];
            end
        end
    end

    // s4: crosses, dots and squared distances
    logic              r_s4_vld;
    t_pt               r_s4_p [4];
    t_diff             r_s4_dax, r_s4_day;
    t_cross            r_s4_c [NPROD];
    logic              r_s4_near [NPAIR];
    logic [SQ_W-1:0]   r_s4_sq [NPAIR];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (adv) begin
            r_s4_vld <= r_s3_vld;
        end
        if (adv) begin
            r_s4_p   <= r_s3_p;
            r_s4_dax <= r_s3_dax;
            r_s4_day <= r_s3_day;
            for (int k = 0; k < NPROD; k++) begin
                if (k < 6) r_s4_c[k] <= CROSS_W'(r_s3_pa[k]) - CROSS_W'(r_s3_pb[k]);
                else       r_s4_c[k] <= CROSS_W'(r_s3_pa[k]) + CROSS_W'(r_s3_pb[k]);
            end
            for (int k = 0; k < NPAIR; k++) begin
                r_s4_near[k] <= r_s3_near[k];
                r_s4_sq[k]   <= SQ_W'(r_s3_mx[k] * r_s3_mx[k]) +
                                SQ_W'(r_s3_my[k] * r_s3_my[k]);
            end
        end
    end

    // s5: tests
    logic              r_s5_vld;
    t_pt               r_s5_p [4];
    t_diff             r_s5_dax, r_s5_day;
    logic              r_s5_den_zero, r_s5_cpar_zero, r_s5_in_unit, r_s5_neg;
    logic [3:0]        r_s5_on;
    logic [NPAIR-1:0]  r_s5_close;
    logic [MAG_W-1:0]  r_s5_tmag, r_s5_dmag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (adv) begin
            r_s5_vld <= r_s4_vld;
        end
        if (adv) begin
            r_s5_p         <= r_s4_p;
            r_s5_dax       <= r_s4_dax;
            r_s5_day       <= r_s4_day;
            r_s5_den_zero  <= (r_s4_c[0] == '0);
            r_s5_cpar_zero <= (r_s4_c[1] == '0);
            r_s5_in_unit   <= f_in_unit(r_s4_c[2], r_s4_c[0]) &&
                              f_in_unit(r_s4_c[1], r_s4_c[0]);
            r_s5_neg       <= r_s4_c[2][CROSS_W-1] ^ r_s4_c[0][CROSS_W-1];
            r_s5_on[0]     <= (r_s4_c[3] == '0) && (r_s4_c[6] <= 0);
            r_s5_on[1]     <= (r_s4_c[4] == '0) && (r_s4_c[7] <= 0);
            r_s5_on[2]     <= (r_s4_c[1] == '0) && (r_s4_c[8] <= 0);
            r_s5_on[3]     <= (r_s4_c[5] == '0) && (r_s4_c[9] <= 0);
            r_s5_tmag      <= f_abs_c(r_s4_c[2]);
            r_s5_dmag      <= f_abs_c(r_s4_c[0]);
            for (int k = 0; k < NPAIR; k++) begin
                r_s5_close[k] <= r_s4_near[k] && (r_s4_sq[k] < SQ_W'(r_tol));
            end
        end
    end

    // s6: overlap points with merging, crossing partial products
    logic [3:0] exist, keep;
    logic [2:0] kept_n;
    t_pt        sel0, sel1;
    logic [1:0] res_kind, res_cnt;
    always_comb begin
        if (r_s5_on[2] && r_s5_on[3])      exist = 4'b1100;
        else if (r_s5_on[0] && r_s5_on[1]) exist = 4'b0011;
        else                               exist = r_s5_on;
        keep[0] = exist[0];
        keep[1] = exist[1] && !(keep[0] && r_s5_close[0]);
        keep[2] = exist[2] && !(keep[0] && r_s5_close[1]) && !(keep[1] && r_s5_close[3]);
        keep[3] = exist[3] && !(keep[0] && r_s5_close[2]) && !(keep[1] && r_s5_close[4])
                           && !(keep[2] && r_s5_close[5]);
        kept_n = '0;
        sel0   = '0;
        sel1   = '0;
        for (int k = 0; k < 4; k++) begin
            if (keep[k]) begin
                if (kept_n == 3'd0)      sel0 = r_s5_p[k];
                else if (kept_n == 3'd1) sel1 = r_s5_p[k];
                kept_n = kept_n + 3'd1;
            end
        end
        res_kind = KIND_NONE;
        res_cnt  = 2'd0;
        if (r_s5_den_zero) begin
            if (r_s5_cpar_zero && kept_n != 3'd0) begin
                res_kind = KIND_OVERLAP;
                res_cnt  = (kept_n > 3'd2) ? 2'd2 : kept_n[1:0];
            end
        end else if (r_s5_in_unit) begin
            res_kind = KIND_CROSS;
            res_cnt  = 2'd1;
        end
        if (res_kind != KIND_OVERLAP) begin
            sel0 = '0;
            sel1 = '0;
        end else if (res_cnt == 2'd1) begin
            sel1 = '0;
        end
    end

    logic [DIFF_W-1:0]      xmag, ymag;
    logic [3*CHUNK_W-1:0]   tpad;
    assign xmag = f_abs_d(r_s5_dax);
    assign ymag = f_abs_d(r_s5_day);
    assign tpad = (3*CHUNK_W)'(r_s5_tmag);

    logic              r_s6_vld;
    logic [1:0]        r_s6_kind, r_s6_cnt;
    t_pt               r_s6_p0, r_s6_p1, r_s6_as;
    logic              r_s6_negx, r_s6_negy;
    logic [MAG_W-1:0]  r_s6_dmag;
    logic [PP_W-1:0]   r_s6_ppx [3];
    logic [PP_W-1:0]   r_s6_ppy [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (adv) begin
            r_s6_vld <= r_s5_vld;
        end
        if (adv) begin
            r_s6_kind <= res_kind;
            r_s6_cnt  <= res_cnt;
            r_s6_p0   <= sel0;
            r_s6_p1   <= sel1;
            r_s6_as   <= r_s5_p[0];
            r_s6_negx <= r_s5_neg ^ r_s5_dax[DIFF_W-1];
            r_s6_negy <= r_s5_neg ^ r_s5_day[DIFF_W-1];
            r_s6_dmag <= r_s5_dmag;
            for (int k = 0; k < 3; k++) begin
                r_s6_ppx[k] <= PP_W'(xmag[COORD_WIDTH-1:0]) *
                               PP_W'(tpad[k*CHUNK_W +: CHUNK_W]);
                r_s6_ppy[k] <= PP_W'(ymag[COORD_WIDTH-1:0]) *
                               PP_W'(tpad[k*CHUNK_W +: CHUNK_W]);
            end
        end
    end

    // s7: dividends
    logic              r_s7_vld;
    logic [1:0]        r_s7_kind, r_s7_cnt;
    t_pt               r_s7_p0, r_s7_p1, r_s7_as;
    logic              r_s7_negx, r_s7_negy;
    logic [MAG_W-1:0]  r_s7_dmag;
    logic [NUM_W-1:0]  r_s7_nx, r_s7_ny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (adv) begin
            r_s7_vld <= r_s6_vld;
        end
        if (adv) begin
            r_s7_kind <= r_s6_kind;
            r_s7_cnt  <= r_s6_cnt;
            r_s7_p0   <= r_s6_p0;
            r_s7_p1   <= r_s6_p1;
            r_s7_as   <= r_s6_as;
            r_s7_negx <= r_s6_negx;
            r_s7_negy <= r_s6_negy;
            r_s7_dmag <= r_s6_dmag;
            r_s7_nx   <= NUM_W'(r_s6_ppx[0]) + (NUM_W'(r_s6_ppx[1]) << CHUNK_W)
                       + (NUM_W'(r_s6_ppx[2]) << (2 * CHUNK_W));
            r_s7_ny   <= NUM_W'(r_s6_ppy[0]) + (NUM_W'(r_s6_ppy[1]) << CHUNK_W)
                       + (NUM_W'(r_s6_ppy[2]) << (2 * CHUNK_W));
        end
    end

    // restoring divider, one quotient bit per stage
    logic              r_dv_vld  [QUO_W];
    logic [1:0]        r_dv_kind [QUO_W];
    logic [1:0]        r_dv_cnt  [QUO_W];
    t_pt               r_dv_p0   [QUO_W];
    t_pt               r_dv_p1   [QUO_W];
    t_pt               r_dv_as   [QUO_W];
    logic              r_dv_negx [QUO_W];
    logic              r_dv_negy [QUO_W];
    logic [MAG_W-1:0]  r_dv_d    [QUO_W];
    logic [NUM_W-1:0]  r_dv_rx   [QUO_W];
    logic [NUM_W-1:0]  r_dv_ry   [QUO_W];
    logic [QUO_W-1:0]  r_dv_qx   [QUO_W];
    logic [QUO_W-1:0]  r_dv_qy   [QUO_W];

    logic [NUM_W-1:0]  n_dv_rx [QUO_W];
    logic [NUM_W-1:0]  n_dv_ry [QUO_W];
    logic [QUO_W-1:0]  n_dv_qx [QUO_W];
    logic [QUO_W-1:0]  n_dv_qy [QUO_W];
    always_comb begin
        logic [NUM_W-1:0]  px, py;
        logic [QUO_W-1:0]  qx, qy;
        logic [MAG_W-1:0]  dd;
        logic [NUM_W:0]    sh, cx, cy;
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                px = r_s7_nx; py = r_s7_ny; qx = '0; qy = '0; dd = r_s7_dmag;
            end else begin
                px = r_dv_rx[k-1]; py = r_dv_ry[k-1];
                qx = r_dv_qx[k-1]; qy = r_dv_qy[k-1]; dd = r_dv_d[k-1];
            end
            sh = (NUM_W+1)'(dd) << (QUO_W - 1 - k);
            cx = {1'b0, px} - sh;
            cy = {1'b0, py} - sh;
            if (!cx[NUM_W]) begin
                px = cx[NUM_W-1:0];
                qx[QUO_W-1-k] = 1'b1;
            end
            if (!cy[NUM_W]) begin
                py = cy[NUM_W-1:0];
                qy[QUO_W-1-k] = 1'b1;
            end
            n_dv_rx[k] = px;
            n_dv_ry[k] = py;
            n_dv_qx[k] = qx;
            n_dv_qy[k] = qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) r_dv_vld[k] <= 1'b0;
        end else if (adv) begin
            r_dv_vld[0] <= r_s7_vld;
            for (int k = 1; k < QUO_W; k++) r_dv_vld[k] <= r_dv_vld[k-1];
        end
        if (adv) begin
            r_dv_kind[0] <= r_s7_kind;
            r_dv_cnt[0]  <= r_s7_cnt;
            r_dv_p0[0]   <= r_s7_p0;
            r_dv_p1[0]   <= r_s7_p1;
            r_dv_as[0]   <= r_s7_as;
            r_dv_negx[0] <= r_s7_negx;
            r_dv_negy[0] <= r_s7_negy;
            r_dv_d[0]    <= r_s7_dmag;
            for (int k = 1; k < QUO_W; k++) begin
                r_dv_kind[k] <= r_dv_kind[k-1];
                r_dv_cnt[k]  <= r_dv_cnt[k-1];
                r_dv_p0[k]   <= r_dv_p0[k-1];
                r_dv_p1[k]   <= r_dv_p1[k-1];
                r_dv_as[k]   <= r_dv_as[k-1];
                r_dv_negx[k] <= r_dv_negx[k-1];
                r_dv_negy[k] <= r_dv_negy[k-1];
                r_dv_d[k]    <= r_dv_d[k-1];
            end
            for (int k = 0; k < QUO_W; k++) begin
                r_dv_rx[k] <= n_dv_rx[k];
                r_dv_ry[k] <= n_dv_ry[k];
                r_dv_qx[k] <= n_dv_qx[k];
                r_dv_qy[k] <= n_dv_qy[k];
            end
        end
    end

    // start + floor(offset), then truncate toward zero
    localparam int FIN_W = COORD_WIDTH + 2;
    localparam int LAST  = QUO_W - 1;

    function automatic logic signed [COORD_WIDTH-1:0] f_finish(
        logic signed [COORD_WIDTH-1:0] start, logic [QUO_W-1:0] q,
        logic rem, logic neg);
        logic signed [FIN_W-1:0] fl, base;
        fl   = neg ? -(FIN_W'(q) + FIN_W'(rem)) : FIN_W'(q);
        base = FIN_W'(start) + fl;
        if (rem && base < 0) base = base + FIN_W'(1);
        f_finish = base[COORD_WIDTH-1:0];
    endfunction

    logic signed [COORD_WIDTH-1:0] cross_x, cross_y;
    assign cross_x = f_finish(r_dv_as[LAST].x, r_dv_qx[LAST], |r_dv_rx[LAST],
                              r_dv_negx[LAST]);
    assign cross_y = f_finish(r_dv_as[LAST].y, r_dv_qy[LAST], |r_dv_ry[LAST],
                              r_dv_negy[LAST]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp_valid <= 1'b0;
        end else if (adv) begin
            o_rsp_valid <= r_dv_vld[LAST];
        end
        if (adv) begin
            o_rsp.contact_kind <= r_dv_kind[LAST];
            o_rsp.point_count  <= r_dv_cnt[LAST];
            if (r_dv_kind[LAST] == KIND_CROSS) begin
                o_rsp.first_x <= FIELD_W'(cross_x);
                o_rsp.first_y <= FIELD_W'(cross_y);
            end else begin
                o_rsp.first_x <= FIELD_W'(r_dv_p0[LAST].x);
                o_rsp.first_y <= FIELD_W'(r_dv_p0[LAST].y);
            end
            o_rsp.second_x <= FIELD_W'(r_dv_p1[LAST].x);
            o_rsp.second_y <= FIELD_W'(r_dv_p1[LAST].y);
        end
    end

endmodule

`default_nettype wire

// ===== src/spi_checker.sv =====
`default_nettype none

module spi_checker
    import spi_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              o_req_stall,
    input wire t_req              i_req,
    input wire logic              o_rsp_valid,
    input wire logic              i_rsp_stall,
    input wire t_rsp              o_rsp,
    input wire logic              i_cfg_wr_en,
    input wire logic [TOL_W-1:0]  i_cfg_wr_data
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp_valid)
        else $error("result valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled result changed");

    a_kind_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |->
            (o_rsp.contact_kind == KIND_NONE && o_rsp.point_count == 2'd0) ||
            (o_rsp.contact_kind == KIND_CROSS && o_rsp.point_count == 2'd1) ||
            (o_rsp.contact_kind == KIND_OVERLAP &&
             (o_rsp.point_count == 2'd1 || o_rsp.point_count == 2'd2)))
        else $error("contact kind and point count disagree");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.point_count != 2'd2 |->
            o_rsp.second_x == '0 && o_rsp.second_y == '0)
        else $error("unused point not zero");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_stall |-> o_rsp_valid && i_rsp_stall)
        else $error("request stalled without a stalled result");

endmodule

bind segment_pair_intersection_unit spi_checker u_spi_checker (.*);

`default_nettype wire
